FILE: src/mersenne_twister_generator_top_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef MERSENNE_TWISTER_GENERATOR_TOP_ASSERT_SVH
`define MERSENNE_TWISTER_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/mtg_pkg.sv
`timescale 1ns / 1ps

package mtg_pkg;

	localparam int STATE_WORDS = 624;
	localparam int ADDR_W      = $clog2(STATE_WORDS);
	localparam int TWIST_SHIFT = 397;
	localparam int FAR_WRAP    = STATE_WORDS - TWIST_SHIFT;

	localparam logic [31:0] INIT_MULT  = 32'h6c078965;
	localparam logic [31:0] MATRIX_A   = 32'h9908b0df;
	localparam logic [31:0] UPPER_MASK = 32'h80000000;
	localparam logic [31:0] LOWER_MASK = 32'h7fffffff;
	localparam logic [31:0] TEMPER_B   = 32'h9d2c5680;
	localparam logic [31:0] TEMPER_C   = 32'hefc60000;

	// Request kinds carried on the input tuser bit.
	localparam logic REQ_RESEED = 1'b0;
	localparam logic REQ_DRAW   = 1'b1;

	// Output tempering of one state word.
	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	// New value of the current word from itself, the next word and the far word.
	function automatic logic [31:0] twist(input logic [31:0] cur, input logic [31:0] nxt,
			input logic [31:0] far);
		logic [31:0] t;
		logic [31:0] r;
		t = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
		r = far ^ (t >> 1);
		if (nxt[0]) begin
			r = r ^ MATRIX_A;
		end
		return r;
	endfunction

endpackage

FILE: src/mersenne_twister_generator_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                   Payload
// s_axis   in         s_axis_tvalid/s_axis_tready tdata: seed_value; tuser: req_type
// m_axis   out        m_axis_tvalid/m_axis_tready tdata: random_value
//
// A draw steps through acceptance, a read of the next word and the far word from the
// two read ports of the state RAM, then a twist and write-back of the word.
// A reseed writes the seed to word 0, fills words 1 to 623 (one multiply per word,
// registered) and runs 624 discarded draws. One request is in flight at a time;
// input is taken again once the result is in the output register. Reset clears
// control state only. A stalled output holds the last draw of a request.

module mersenne_twister_generator_top
	import mtg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] seed_value
	input  logic        s_axis_tuser,   // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [31:0] random_value
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SEEDW  = 6'b000010,
		ST_MUL    = 6'b000100,
		ST_ADD    = 6'b001000,
		ST_DREAD  = 6'b010000,
		ST_DWRITE = 6'b100000
	} state_t;

	localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(STATE_WORDS - 1);

	state_t            state_q;
	logic [ADDR_W-1:0] pos_q;
	logic [ADDR_W-1:0] cnt_q;
	logic              discard_q;
	logic [31:0]       prev_q;
	logic [31:0]       prod_q;
	logic [31:0]       cur_q;
	logic              out_valid_q;
	logic [31:0]       out_data_q;

	logic [ADDR_W-1:0] nxt_pos;
	logic [ADDR_W-1:0] far_pos;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [31:0]       ram_wdata;
	logic [31:0]       rd_nxt;
	logic [31:0]       rd_far;
	logic [31:0]       fill_word;
	logic [31:0]       mix;
	logic              out_free;
	logic              last_draw;
	logic              draw_go;

	// Neighbor positions of the read position, with wrap.
	always_comb begin
		nxt_pos = (pos_q == LAST_POS) ? '0 : pos_q + ADDR_W'(1);
		if (pos_q >= ADDR_W'(FAR_WRAP)) begin
			far_pos = pos_q - ADDR_W'(FAR_WRAP);
		end else begin
			far_pos = pos_q + ADDR_W'(TWIST_SHIFT);
		end
	end

	assign fill_word = prod_q + 32'(cnt_q);
	assign mix       = prev_q ^ (prev_q >> 30);
	assign out_free  = !out_valid_q || m_axis_tready;
	assign last_draw = !discard_q || (cnt_q == LAST_POS);
	assign draw_go   = !last_draw || out_free;

	// Write port: seed word, fill words, then twisted words.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = twist(cur_q, rd_nxt, rd_far);
		case (state_q)
			ST_SEEDW: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = prev_q;
			end
			ST_ADD: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = fill_word;
			end
			ST_DWRITE: begin
				ram_we = draw_go;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	mtg_ram #(
		.WIDTH(32),
		.DEPTH(STATE_WORDS)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr_a(nxt_pos),
		.rdata_a(rd_nxt),
		.raddr_b(far_pos),
		.rdata_b(rd_far)
	);

	// Sequencer and position registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			cnt_q       <= '0;
			discard_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// The output word is loaded by the last draw and dropped once taken.
			if (state_q == ST_DWRITE && draw_go && last_draw) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						if (s_axis_tuser == REQ_RESEED) begin
							state_q <= ST_SEEDW;
						end else begin
							discard_q <= 1'b0;
							state_q   <= ST_DREAD;
						end
					end
				end
				ST_SEEDW: begin
					cnt_q   <= ADDR_W'(1);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (cnt_q == LAST_POS) begin
						cnt_q     <= '0;
						pos_q     <= '0;
						discard_q <= 1'b1;
						state_q   <= ST_DREAD;
					end else begin
						cnt_q   <= cnt_q + ADDR_W'(1);
						state_q <= ST_MUL;
					end
				end
				ST_DREAD: begin
					state_q <= ST_DWRITE;
				end
				ST_DWRITE: begin
					if (draw_go) begin
						pos_q <= nxt_pos;
						cnt_q <= cnt_q + ADDR_W'(1);
						if (last_draw) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DREAD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: fill chain, cached current word and output word.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid && s_axis_tuser == REQ_RESEED) begin
					prev_q <= s_axis_tdata;
					cur_q  <= s_axis_tdata;
				end
			end
			ST_MUL: begin
				prod_q <= mix * INIT_MULT;
			end
			ST_ADD: begin
				prev_q <= fill_word;
			end
			ST_DWRITE: begin
				if (draw_go) begin
					cur_q <= rd_nxt;
					if (last_draw) begin
						out_data_q <= discard_q ? 32'd0 : temper(cur_q);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

FILE: src/mtg_ram.sv
`timescale 1ns / 1ps

module mtg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and two registered read ports.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: src/mtg_checker.sv
`timescale 1ns / 1ps
`include "mersenne_twister_generator_top_assert.svh"

module mtg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [31:0] s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	// A waiting output word stays valid and unchanged.
	`MTG_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")

	// Only one request is in flight: the input closes right after a word is taken.
	`MTG_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a request is in flight")

	// A draw with a free output register answers once it has passed the read and write states.
	`MTG_ASSERT_IMPLY(a_draw_latency, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser && (!m_axis_tvalid || m_axis_tready), ##3 m_axis_tvalid, "draw result late")

	// Input does not reopen right after a draw is accepted while no answer is waiting.
	`MTG_ASSERT_NEXT(a_ready_after_out, clk, arst_n, !s_axis_tready && !m_axis_tvalid && $past(s_axis_tready) && s_axis_tuser, !s_axis_tready, "input reopened before a draw finished")

endmodule

bind mersenne_twister_generator_top mtg_checker u_mtg_checker (.*);
